// ===== rtl/core/linear_adrc_step_top_assert.svh =====
// Assertion macros shared by the checker of linear_adrc_step_top.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef LINEAR_ADRC_STEP_TOP_ASSERT_SVH
`define LINEAR_ADRC_STEP_TOP_ASSERT_SVH

// Same-cycle implication: the consequent must hold in the cycle of the antecedent.
`define LADRC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define LADRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ladrc_pkg.sv =====
// Package for the second-order linear ADRC step block.
// Holds the microcode, the operand and operation codes, and the control types.
// No dependencies.
`timescale 1ns / 1ps

package ladrc_pkg;

  localparam int W = 64;
  localparam int CFG_W = 41;
  localparam int IDX_W = 3;
  localparam int TMP_DEPTH = 16;
  localparam int PC_W = 7;

  localparam logic [W-1:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [W-1:0] S_MIN = 64'h8000_0000_0000_0000;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_STEP_PERIOD = 3'd0;
  localparam logic [IDX_W-1:0] REG_TRACK_SPEED = 3'd1;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RATE_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PLANT_GAIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_POLE_FACTOR = 3'd5;
  localparam logic [IDX_W-1:0] REG_INT_GAIN    = 3'd6;
  localparam logic [IDX_W-1:0] REG_INT_WINDOW  = 3'd7;

  localparam logic [24:0] RST_STEP_PERIOD = 25'd16777;
  localparam logic [40:0] RST_TRACK_SPEED = 41'd30198988800;
  localparam logic [40:0] RST_PROP_GAIN   = 41'd100663296;
  localparam logic [40:0] RST_RATE_GAIN   = 41'd8388608;
  localparam logic [40:0] RST_PLANT_GAIN  = 41'd16777216;
  localparam logic [24:0] RST_POLE_FACTOR = 25'd8388608;
  localparam logic [40:0] RST_INT_GAIN    = 41'd0;
  localparam logic [40:0] RST_INT_WINDOW  = 41'd0;

  // Sample operation codes
  localparam logic [1:0] CMD_ANGLE = 2'd0;
  localparam logic [1:0] CMD_SPEED = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_HOLD  = 2'd3;

  // Operand / destination codes: temporaries below 32, named values from 32 up
  typedef logic [5:0] src_t;
  localparam src_t SRC_T0  = 6'd0;
  localparam src_t SRC_T1  = 6'd1;
  localparam src_t SRC_T2  = 6'd2;
  localparam src_t SRC_T3  = 6'd3;
  localparam src_t SRC_T4  = 6'd4;
  localparam src_t SRC_T5  = 6'd5;
  localparam src_t SRC_T6  = 6'd6;
  localparam src_t SRC_T7  = 6'd7;
  localparam src_t SRC_T8  = 6'd8;
  localparam src_t SRC_T9  = 6'd9;
  localparam src_t SRC_T10 = 6'd10;
  localparam src_t SRC_ZERO   = 6'd32;
  localparam src_t SRC_ONE    = 6'd33;
  localparam src_t SRC_TWO    = 6'd34;
  localparam src_t SRC_THREE  = 6'd35;
  localparam src_t SRC_FIVE   = 6'd36;
  localparam src_t SRC_H      = 6'd37;
  localparam src_t SRC_R      = 6'd38;
  localparam src_t SRC_KP     = 6'd39;
  localparam src_t SRC_KD     = 6'd40;
  localparam src_t SRC_B0     = 6'd41;
  localparam src_t SRC_BETA   = 6'd42;
  localparam src_t SRC_KI     = 6'd43;
  localparam src_t SRC_SP     = 6'd44;
  localparam src_t SRC_UD     = 6'd45;
  localparam src_t SRC_Y      = 6'd46;
  localparam src_t SRC_RATE   = 6'd47;
  localparam src_t SRC_TP     = 6'd48;
  localparam src_t SRC_TV     = 6'd49;
  localparam src_t SRC_ZP     = 6'd50;
  localparam src_t SRC_ZV     = 6'd51;
  localparam src_t SRC_ZD     = 6'd52;
  localparam src_t SRC_ISUM   = 6'd53;
  localparam src_t SRC_LRAW   = 6'd54;
  localparam src_t SRC_LDRIVE = 6'd55;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_HALF, OP_CMPW
  } alu_op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS, COND_WIN, COND_NOWIN
  } cond_t;

  typedef struct packed {
    alu_op_t op;
    cond_t   cond;
    src_t    dst;
    src_t    a;
    src_t    b;
    logic    branch;
    logic    last;
  } uinstr_t;

  localparam logic [PC_W-1:0] PC_BRANCH    = 7'd50;
  localparam logic [PC_W-1:0] PC_ANGLE     = 7'd51;
  localparam logic [PC_W-1:0] PC_ANGLE_END = 7'd60;
  localparam logic [PC_W-1:0] PC_SPEED     = 7'd61;
  localparam logic [PC_W-1:0] PC_SPEED_END = 7'd65;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_FETCH, ST_LOAD, ST_RUN, ST_WRITE, ST_CLEAR, ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic    take;
    logic    ld;
    logic    run;
    logic    wr;
    logic    clr_obs;
    uinstr_t ui;
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic       win;
    logic [1:0] op;
  } stat_t;

  function automatic uinstr_t mk(alu_op_t op, src_t d, src_t a, src_t b);
    uinstr_t u;
    u.op = op;
    u.cond = COND_ALWAYS;
    u.dst = d;
    u.a = a;
    u.b = b;
    u.branch = 1'b0;
    u.last = 1'b0;
    return u;
  endfunction

  function automatic uinstr_t ucode(logic [PC_W-1:0] pc);
    uinstr_t u;
    case (pc)
      // tracking differentiator
      7'd0:  u = mk(OP_MUL, SRC_T0, SRC_R, SRC_R);
      7'd1:  u = mk(OP_SUB, SRC_T1, SRC_TP, SRC_SP);
      7'd2:  u = mk(OP_MUL, SRC_T1, SRC_T0, SRC_T1);
      7'd3:  u = mk(OP_SUB, SRC_T1, SRC_ZERO, SRC_T1);
      7'd4:  u = mk(OP_MUL, SRC_T2, SRC_R, SRC_TV);
      7'd5:  u = mk(OP_ADD, SRC_T2, SRC_T2, SRC_T2);
      7'd6:  u = mk(OP_SUB, SRC_T0, SRC_T1, SRC_T2);
      7'd7:  u = mk(OP_MUL, SRC_T3, SRC_TV, SRC_H);
      7'd8:  u = mk(OP_ADD, SRC_TP, SRC_TP, SRC_T3);
      7'd9:  u = mk(OP_MUL, SRC_T1, SRC_T0, SRC_H);
      7'd10: u = mk(OP_ADD, SRC_TV, SRC_TV, SRC_T1);
      // observer coefficients
      7'd11: u = mk(OP_MUL, SRC_T0, SRC_H, SRC_H);
      7'd12: u = mk(OP_SUB, SRC_T1, SRC_BETA, SRC_ONE);
      7'd13: u = mk(OP_MUL, SRC_T2, SRC_T1, SRC_T1);
      7'd14: u = mk(OP_ADD, SRC_T3, SRC_BETA, SRC_FIVE);
      7'd15: u = mk(OP_MUL, SRC_T3, SRC_T2, SRC_T3);
      7'd16: u = mk(OP_MUL, SRC_T4, SRC_T2, SRC_T1);
      7'd17: u = mk(OP_SUB, SRC_T5, SRC_Y, SRC_ZP);
      // observer position
      7'd18: u = mk(OP_MUL, SRC_T6, SRC_H, SRC_ZV);
      7'd19: u = mk(OP_MUL, SRC_T7, SRC_T0, SRC_ZD);
      7'd20: u = mk(OP_HALF, SRC_T7, SRC_T7, SRC_ZERO);
      7'd21: u = mk(OP_ADD, SRC_T6, SRC_T6, SRC_T7);
      7'd22: u = mk(OP_ADD, SRC_T7, SRC_BETA, SRC_BETA);
      7'd23: u = mk(OP_ADD, SRC_T7, SRC_T7, SRC_BETA);
      7'd24: u = mk(OP_SUB, SRC_T7, SRC_T7, SRC_TWO);
      7'd25: u = mk(OP_MUL, SRC_T7, SRC_T7, SRC_ZP);
      7'd26: u = mk(OP_ADD, SRC_T6, SRC_T6, SRC_T7);
      7'd27: u = mk(OP_ADD, SRC_T7, SRC_BETA, SRC_BETA);
      7'd28: u = mk(OP_ADD, SRC_T7, SRC_T7, SRC_BETA);
      7'd29: u = mk(OP_SUB, SRC_T7, SRC_T7, SRC_THREE);
      7'd30: u = mk(OP_MUL, SRC_T7, SRC_T7, SRC_Y);
      7'd31: u = mk(OP_SUB, SRC_T6, SRC_T6, SRC_T7);
      7'd32: u = mk(OP_MUL, SRC_T7, SRC_B0, SRC_T0);
      7'd33: u = mk(OP_MUL, SRC_T7, SRC_T7, SRC_UD);
      7'd34: u = mk(OP_HALF, SRC_T7, SRC_T7, SRC_ZERO);
      7'd35: u = mk(OP_ADD, SRC_T6, SRC_T6, SRC_T7);
      // observer velocity
      7'd36: u = mk(OP_MUL, SRC_T8, SRC_H, SRC_ZD);
      7'd37: u = mk(OP_ADD, SRC_T8, SRC_ZV, SRC_T8);
      7'd38: u = mk(OP_MUL, SRC_T9, SRC_B0, SRC_H);
      7'd39: u = mk(OP_MUL, SRC_T9, SRC_T9, SRC_UD);
      7'd40: u = mk(OP_ADD, SRC_T8, SRC_T8, SRC_T9);
      7'd41: u = mk(OP_MUL, SRC_T9, SRC_T5, SRC_T3);
      7'd42: u = mk(OP_ADD, SRC_T10, SRC_H, SRC_H);
      7'd43: u = mk(OP_DIV, SRC_T9, SRC_T9, SRC_T10);
      7'd44: u = mk(OP_ADD, SRC_T8, SRC_T8, SRC_T9);
      // observer disturbance and commit
      7'd45: u = mk(OP_MUL, SRC_T9, SRC_T5, SRC_T4);
      7'd46: u = mk(OP_DIV, SRC_T9, SRC_T9, SRC_T0);
      7'd47: u = mk(OP_SUB, SRC_ZD, SRC_ZD, SRC_T9);
      7'd48: u = mk(OP_ADD, SRC_ZP, SRC_T6, SRC_ZERO);
      7'd49: u = mk(OP_ADD, SRC_ZV, SRC_T8, SRC_ZERO);
      7'd50: u = mk(OP_SUB, SRC_T0, SRC_TP, SRC_Y);
      // angle law
      7'd51: u = mk(OP_MUL, SRC_T1, SRC_KP, SRC_T0);
      7'd52: u = mk(OP_MUL, SRC_T2, SRC_KD, SRC_RATE);
      7'd53: u = mk(OP_SUB, SRC_LRAW, SRC_T1, SRC_T2);
      7'd54: u = mk(OP_DIV, SRC_T3, SRC_ZD, SRC_B0);
      7'd55: u = mk(OP_SUB, SRC_T3, SRC_LRAW, SRC_T3);
      7'd56: u = mk(OP_CMPW, SRC_ZERO, SRC_T0, SRC_ZERO);
      7'd57: u = mk(OP_MUL, SRC_T4, SRC_KI, SRC_T0);
      7'd58: u = mk(OP_ADD, SRC_ISUM, SRC_ISUM, SRC_T4);
      7'd59: u = mk(OP_ADD, SRC_ISUM, SRC_ZERO, SRC_ZERO);
      7'd60: u = mk(OP_ADD, SRC_LDRIVE, SRC_T3, SRC_ISUM);
      // speed law
      7'd61: u = mk(OP_MUL, SRC_T1, SRC_KP, SRC_T0);
      7'd62: u = mk(OP_MUL, SRC_T2, SRC_KD, SRC_ZV);
      7'd63: u = mk(OP_SUB, SRC_LRAW, SRC_T1, SRC_T2);
      7'd64: u = mk(OP_SUB, SRC_T3, SRC_LRAW, SRC_ZD);
      7'd65: u = mk(OP_DIV, SRC_LDRIVE, SRC_T3, SRC_B0);
      default: u = mk(OP_CMPW, SRC_ZERO, SRC_ZERO, SRC_ZERO);
    endcase
    if (pc == 7'd57 || pc == 7'd58) u.cond = COND_WIN;
    if (pc == 7'd59) u.cond = COND_NOWIN;
    if (pc == PC_BRANCH) u.branch = 1'b1;
    if (pc == PC_ANGLE_END || pc == PC_SPEED_END || pc > PC_SPEED_END) u.last = 1'b1;
    return u;
  endfunction

endpackage

// ===== rtl/core/ladrc_if.sv =====
// Handshake channel interfaces for the ADRC step block: sample in, result out.
// Depends on nothing.
`timescale 1ns / 1ps

interface ladrc_sample_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic signed [63:0] setpoint;
  logic signed [63:0] applied_drive;
  logic signed [63:0] measured;
  logic signed [63:0] measured_rate;
  modport source(output valid, op, setpoint, applied_drive, measured, measured_rate,
                 input ready);
  modport sink(input valid, op, setpoint, applied_drive, measured, measured_rate,
               output ready);
endinterface

interface ladrc_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] drive;
  logic signed [63:0] drive_raw;
  logic signed [63:0] tracked_value;
  logic signed [63:0] disturbance_estimate;
  logic               saturated;
  modport source(output valid, drive, drive_raw, tracked_value, disturbance_estimate,
                 saturated, input ready);
  modport sink(input valid, drive, drive_raw, tracked_value, disturbance_estimate,
               saturated, output ready);
endinterface

// ===== rtl/core/ladrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ladrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ladrc_dp.sv =====
// Datapath of the ADRC step block: configuration, state, temporaries, shared ALU.
// Depends on ladrc_pkg and ladrc_ram.
`timescale 1ns / 1ps

module ladrc_dp #(
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ladrc_pkg::cmd_t             cmd,
  output ladrc_pkg::stat_t            stat,
  input  logic                        cfg_we,
  input  logic [ladrc_pkg::IDX_W-1:0] cfg_index,
  input  logic [ladrc_pkg::CFG_W-1:0] cfg_data,
  input  logic [1:0]                  in_op,
  input  logic [63:0]                 in_setpoint,
  input  logic [63:0]                 in_applied_drive,
  input  logic [63:0]                 in_measured,
  input  logic [63:0]                 in_measured_rate,
  output logic [63:0]                 drive,
  output logic [63:0]                 drive_raw,
  output logic [63:0]                 tracked_value,
  output logic [63:0]                 disturbance_estimate,
  output logic                        saturated
);
  import ladrc_pkg::*;

  localparam logic [W-1:0] ONE   = 64'd1 << FRAC_BITS;
  localparam logic [W-1:0] TWO   = ONE * 2;
  localparam logic [W-1:0] THREE = ONE * 3;
  localparam logic [W-1:0] FIVE  = ONE * 5;
  localparam int TAW = $clog2(TMP_DEPTH);

  logic [24:0] h_reg, beta_reg;
  logic [40:0] r_reg, kp_reg, kd_reg, b0_reg, ki_reg, win_reg;
  logic [1:0]  op_q;
  logic [W-1:0] sp, ud, y, rate;
  logic [W-1:0] tp, tv, zp, zv, zd, isum, lraw, ldrive;
  logic [W-1:0] ram_a, ram_b, va, vb, opa, opb, ma, mb;
  logic [127:0] acc, nq, pp_sh;
  logic [W-1:0] rem, rem_n, prod, res;
  logic [64:0]  rem2, dvs, sum, dif, pk_mul, pk_div;
  logic [31:0]  xs, ys;
  logic [7:0]   cnt;
  logic         ge, done, win, sat, res_sat, wr_en;

  function automatic logic [W-1:0] mag(logic [W-1:0] v);
    return v[W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [64:0] pack(logic neg, logic hi_nz, logic [W-1:0] m);
    logic [W-1:0] lim;
    lim = neg ? S_MIN : S_MAX;
    if (hi_nz || m > lim) return {1'b1, neg ? S_MIN : S_MAX};
    return {1'b0, neg ? (~m + 64'd1) : m};
  endfunction

  function automatic logic [W-1:0] pick(src_t s, logic [W-1:0] ramv);
    case (s)
      SRC_ZERO:   return '0;
      SRC_ONE:    return ONE;
      SRC_TWO:    return TWO;
      SRC_THREE:  return THREE;
      SRC_FIVE:   return FIVE;
      SRC_H:      return {39'b0, h_reg};
      SRC_R:      return {23'b0, r_reg};
      SRC_KP:     return {23'b0, kp_reg};
      SRC_KD:     return {23'b0, kd_reg};
      SRC_B0:     return {23'b0, b0_reg};
      SRC_BETA:   return {39'b0, beta_reg};
      SRC_KI:     return {23'b0, ki_reg};
      SRC_SP:     return sp;
      SRC_UD:     return ud;
      SRC_Y:      return y;
      SRC_RATE:   return rate;
      SRC_TP:     return tp;
      SRC_TV:     return tv;
      SRC_ZP:     return zp;
      SRC_ZV:     return zv;
      SRC_ZD:     return zd;
      SRC_ISUM:   return isum;
      SRC_LRAW:   return lraw;
      SRC_LDRIVE: return ldrive;
      default:    return ramv;
    endcase
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h_reg    <= RST_STEP_PERIOD;
      r_reg    <= RST_TRACK_SPEED;
      kp_reg   <= RST_PROP_GAIN;
      kd_reg   <= RST_RATE_GAIN;
      b0_reg   <= RST_PLANT_GAIN;
      beta_reg <= RST_POLE_FACTOR;
      ki_reg   <= RST_INT_GAIN;
      win_reg  <= RST_INT_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_PERIOD: h_reg    <= cfg_data[24:0];
        REG_TRACK_SPEED: r_reg    <= cfg_data;
        REG_PROP_GAIN:   kp_reg   <= cfg_data;
        REG_RATE_GAIN:   kd_reg   <= cfg_data;
        REG_PLANT_GAIN:  b0_reg   <= cfg_data;
        REG_POLE_FACTOR: beta_reg <= cfg_data[24:0];
        REG_INT_GAIN:    ki_reg   <= cfg_data;
        REG_INT_WINDOW:  win_reg  <= cfg_data;
      endcase
    end
  end

  // Sample capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q <= in_op;
      sp   <= in_setpoint;
      ud   <= in_applied_drive;
      y    <= in_measured;
      rate <= in_measured_rate;
    end
  end

  // Temporaries: two copies give two read ports
  assign wr_en = cmd.wr && (cmd.ui.op != OP_CMPW);

  ladrc_ram #(.WIDTH(W), .DEPTH(TMP_DEPTH)) u_tmp_a (
    .clk(clk), .we(wr_en && !cmd.ui.dst[5]), .waddr(cmd.ui.dst[TAW-1:0]), .wdata(res),
    .raddr(cmd.ui.a[TAW-1:0]), .rdata(ram_a)
  );

  ladrc_ram #(.WIDTH(W), .DEPTH(TMP_DEPTH)) u_tmp_b (
    .clk(clk), .we(wr_en && !cmd.ui.dst[5]), .waddr(cmd.ui.dst[TAW-1:0]), .wdata(res),
    .raddr(cmd.ui.b[TAW-1:0]), .rdata(ram_b)
  );

  assign va = pick(cmd.ui.a, ram_a);
  assign vb = pick(cmd.ui.b, ram_b);

  // Multiplier: four 32x32 partial products, one per cycle
  assign ma = mag(opa);
  assign mb = mag(opb);

  always_comb begin
    case (cnt[1:0])
      2'd0: begin xs = ma[31:0];  ys = mb[31:0];  end
      2'd1: begin xs = ma[31:0];  ys = mb[63:32]; end
      2'd2: begin xs = ma[63:32]; ys = mb[31:0];  end
      default: begin xs = ma[63:32]; ys = mb[63:32]; end
    endcase
  end

  assign prod = {32'b0, xs} * {32'b0, ys};

  always_comb begin
    case (cnt[1:0])
      2'd0:    pp_sh = {64'b0, prod};
      2'd1,
      2'd2:    pp_sh = {32'b0, prod, 32'b0};
      default: pp_sh = {prod, 64'b0};
    endcase
  end

  // Divider: restoring, one quotient bit per cycle
  assign rem2  = {rem, nq[127]};
  assign dvs   = {1'b0, mb};
  assign ge    = rem2 >= dvs;
  assign rem_n = ge ? 64'(rem2 - dvs) : rem2[63:0];

  always_comb begin
    case (cmd.ui.op)
      OP_MUL:  done = (cnt == 8'd4);
      OP_DIV:  done = (cnt == 8'd128);
      default: done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      opa <= va;
      opb <= vb;
      acc <= '0;
      rem <= '0;
      cnt <= '0;
      nq  <= {64'b0, mag(va)} << FRAC_BITS;
    end else if (cmd.run && !done) begin
      cnt <= cnt + 8'd1;
      if (cmd.ui.op == OP_MUL) begin
        acc <= acc + pp_sh;
      end else begin
        rem <= rem_n;
        nq  <= {nq[126:0], ge};
      end
    end
  end

  // Result formation with saturation
  assign sum    = {opa[63], opa} + {opb[63], opb};
  assign dif    = {opa[63], opa} - {opb[63], opb};
  assign pk_mul = pack(opa[63] ^ opb[63], |acc[127:64+FRAC_BITS],
                       acc[63+FRAC_BITS:FRAC_BITS]);
  assign pk_div = pack(opa[63] ^ opb[63], |nq[127:64], nq[63:0]);

  always_comb begin
    res_sat = 1'b0;
    res     = '0;
    case (cmd.ui.op)
      OP_ADD: begin
        res_sat = sum[64] ^ sum[63];
        res     = res_sat ? (sum[64] ? S_MIN : S_MAX) : sum[63:0];
      end
      OP_SUB: begin
        res_sat = dif[64] ^ dif[63];
        res     = res_sat ? (dif[64] ? S_MIN : S_MAX) : dif[63:0];
      end
      OP_MUL: {res_sat, res} = pk_mul;
      OP_DIV: begin
        if (opb == '0) begin
          res_sat = 1'b1;
          res     = (opa == '0) ? '0 : (opa[63] ? S_MIN : S_MAX);
        end else begin
          {res_sat, res} = pk_div;
        end
      end
      OP_HALF: res = 64'($signed(opa + {63'b0, opa[63]}) >>> 1);
      default: ;
    endcase
  end

  // Controller state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tp     <= '0;
      tv     <= '0;
      zp     <= '0;
      zv     <= '0;
      zd     <= '0;
      isum   <= '0;
      lraw   <= '0;
      ldrive <= '0;
      win    <= 1'b0;
      sat    <= 1'b0;
    end else begin
      if (cmd.take) sat <= 1'b0;
      if (cmd.clr_obs) begin
        zp <= '0;
        zv <= '0;
        zd <= '0;
      end
      if (cmd.wr && cmd.ui.op == OP_CMPW) win <= ma < {23'b0, win_reg};
      if (wr_en) begin
        sat <= sat | res_sat;
        case (cmd.ui.dst)
          SRC_TP:     tp     <= res;
          SRC_TV:     tv     <= res;
          SRC_ZP:     zp     <= res;
          SRC_ZV:     zv     <= res;
          SRC_ZD:     zd     <= res;
          SRC_ISUM:   isum   <= res;
          SRC_LRAW:   lraw   <= res;
          SRC_LDRIVE: ldrive <= res;
          default: ;
        endcase
      end
    end
  end

  assign stat.done = done;
  assign stat.win  = win;
  assign stat.op   = op_q;

  assign drive                = ldrive;
  assign drive_raw            = lraw;
  assign tracked_value        = tp;
  assign disturbance_estimate = zd;
  assign saturated            = sat;

endmodule

// ===== rtl/core/ladrc_ctrl.sv =====
// Sequencer of the ADRC step block: walks the microcode and runs the handshakes.
// Depends on ladrc_pkg.
`timescale 1ns / 1ps

module ladrc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ladrc_pkg::stat_t stat,
  output ladrc_pkg::cmd_t  cmd
);
  import ladrc_pkg::*;

  ctrl_state_t     state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  uinstr_t         ui;
  logic            skip;

  assign ui   = ucode(pc);
  assign skip = (ui.cond == COND_WIN && !stat.win) || (ui.cond == COND_NOWIN && stat.win);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      ST_IDLE: begin
        pc_next = '0;
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          CMD_ANGLE, CMD_SPEED: state_next = ST_FETCH;
          CMD_CLEAR:            state_next = ST_CLEAR;
          CMD_HOLD:             state_next = ST_OUT;
        endcase
      end
      ST_FETCH: begin
        if (skip) pc_next = pc + 7'd1;
        else state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_RUN;
      ST_RUN: begin
        if (stat.done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (ui.branch) begin
          pc_next    = (stat.op == CMD_ANGLE) ? PC_ANGLE : PC_SPEED;
          state_next = ST_FETCH;
        end else if (ui.last) begin
          state_next = ST_OUT;
        end else begin
          pc_next    = pc + 7'd1;
          state_next = ST_FETCH;
        end
      end
      ST_CLEAR: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.ui    = ui;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DISPATCH, ST_FETCH: ;
      ST_LOAD:  cmd.ld = 1'b1;
      ST_RUN:   cmd.run = 1'b1;
      ST_WRITE: cmd.wr = 1'b1;
      ST_CLEAR: cmd.clr_obs = 1'b1;
      ST_OUT:   out_valid = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/linear_adrc_step_top.sv =====
// Second-order linear ADRC step: one sample transaction in, one result transaction out.
// Depends on ladrc_pkg, ladrc_if, ladrc_ctrl and ladrc_dp.
//
// One sample at a time: the block takes a sample, runs a microcoded sequence of
// saturating Q(64-FRAC_BITS).FRAC_BITS operations on one shared ALU, then holds the
// result until it is taken, and only then takes the next sample. Each microcode step
// passes through operand fetch from the temporary RAM, operand load, execute and
// write back; a multiply executes as four 32x32 partial products and a divide
// takes one quotient bit per cycle; a step skipped by the integral window costs
// only a fetch. The time of an angle-law or speed-law sample is set almost entirely
// by its three divides and the serial multiplier; a clear-observer sample passes
// through dispatch and clear before its result is offered, and a no-op sample through
// dispatch alone. Configuration writes take effect at once and belong between
// transactions.
`timescale 1ns / 1ps

module linear_adrc_step_top #(
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  ladrc_sample_if.sink                sample,
  ladrc_result_if.source              result,
  input  logic                        cfg_we,
  input  logic [ladrc_pkg::IDX_W-1:0] cfg_index,
  input  logic [ladrc_pkg::CFG_W-1:0] cfg_data
);
  import ladrc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: owns both handshakes and steps through the microcode.
  ladrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: holds configuration, controller state and the result registers,
  // which drive the result channel directly while it waits.
  ladrc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_op               (sample.op),
    .in_setpoint         (sample.setpoint),
    .in_applied_drive    (sample.applied_drive),
    .in_measured         (sample.measured),
    .in_measured_rate    (sample.measured_rate),
    .drive               (result.drive),
    .drive_raw           (result.drive_raw),
    .tracked_value       (result.tracked_value),
    .disturbance_estimate(result.disturbance_estimate),
    .saturated           (result.saturated)
  );

endmodule

// ===== rtl/core/ladrc_checker.sv =====
// Port-level checker for linear_adrc_step_top, attached by bind.
// Depends on linear_adrc_step_top_assert.svh.
`timescale 1ns / 1ps
`include "linear_adrc_step_top_assert.svh"

module ladrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_drive
);

  `LADRC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_drive), "result dropped or changed while stalled")
  `LADRC_ASSERT_NOW(a_one_at_a_time, clk, rst, out_valid, !in_ready, "sample taken while a result is pending")
  `LADRC_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, in_ready && !out_valid, "block not idle after reset")
  `LADRC_ASSERT_NEXT(a_back_to_idle, clk, rst, out_valid && out_ready, in_ready && !out_valid, "block not idle after result transaction")

endmodule

bind linear_adrc_step_top ladrc_checker u_ladrc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_drive(result.drive)
);

// ===== tb/ladrc_step_checker.sv =====
// Checker for linear_adrc_step_top: watches the sample, result and configuration ports,
// predicts every result in fixed point, and counts mismatches.
// Depends on ladrc_pkg and the channel interfaces in ladrc_if.
`timescale 1ns / 1ps

module ladrc_step_checker #(
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  ladrc_sample_if                     sample,
  ladrc_result_if                     result,
  input  logic                        cfg_we,
  input  logic [ladrc_pkg::IDX_W-1:0] cfg_index,
  input  logic [ladrc_pkg::CFG_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          results_seen
);
  import ladrc_pkg::*;

  typedef logic signed [63:0] q_t;
  typedef struct {
    q_t   drive;
    q_t   raw;
    q_t   tracked;
    q_t   est;
    logic sat;
  } drive_rec_t;

  localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t QMIN = 64'sh8000_0000_0000_0000;
  localparam q_t ONE  = q_t'(1) <<< FRAC_BITS;

  drive_rec_t  expected_drives[$];
  logic [63:0] gains[8];
  q_t tr_pos, tr_vel, ob_pos, ob_vel, ob_dist, int_sum, prev_drive, prev_raw;
  logic sat_seen;

  function automatic q_t q_add(q_t a, q_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin sat_seen = 1; return QMAX; end
    if (s < -65'sh0_8000_0000_0000_0000) begin sat_seen = 1; return QMIN; end
    return s[63:0];
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin sat_seen = 1; return QMAX; end
    if (s < -65'sh0_8000_0000_0000_0000) begin sat_seen = 1; return QMIN; end
    return s[63:0];
  endfunction

  function automatic logic [63:0] magn(q_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // fold a sign and an unsigned magnitude back into range
  function automatic q_t q_pack(logic neg, logic over, logic [63:0] m);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (over || m > lim) begin
      sat_seen = 1;
      return neg ? QMIN : QMAX;
    end
    return neg ? q_t'(-m) : q_t'(m);
  endfunction

  function automatic q_t q_mul(q_t a, q_t b);
    logic [127:0] p;
    p = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> FRAC_BITS;
    return q_pack(a[63] != b[63], p[127:64] != 0, p[63:0]);
  endfunction

  function automatic q_t q_div(q_t a, q_t b);
    logic [127:0] n, qo;
    if (b == 0) begin
      sat_seen = 1;
      return a > 0 ? QMAX : (a < 0 ? QMIN : q_t'(0));
    end
    n  = {64'd0, magn(a)} << FRAC_BITS;
    qo = n / {64'd0, magn(b)};
    return q_pack(a[63] != b[63], qo[127:64] != 0, qo[63:0]);
  endfunction

  function automatic drive_rec_t adrc_step(logic [1:0] op, q_t sp, q_t ud, q_t y, q_t rate);
    drive_rec_t rec;
    q_t h, r, kp, kd, b0, beta, ki, fh, hh, bm1, sq, qf, cf, d, n1, n2, n3, e1, u0, u;
    h = gains[REG_STEP_PERIOD];   r = gains[REG_TRACK_SPEED];
    kp = gains[REG_PROP_GAIN];    kd = gains[REG_RATE_GAIN];
    b0 = gains[REG_PLANT_GAIN];   beta = gains[REG_POLE_FACTOR];
    ki = gains[REG_INT_GAIN];
    sat_seen = 0;
    if (op == CMD_CLEAR || op == CMD_HOLD) begin
      if (op == CMD_CLEAR) begin
        ob_pos = 0; ob_vel = 0; ob_dist = 0;
      end
      rec = '{prev_drive, prev_raw, tr_pos, ob_dist, 1'b0};
      return rec;
    end
    // tracking differentiator on the setpoint
    fh = q_sub(q_sub(0, q_mul(q_mul(r, r), q_sub(tr_pos, sp))),
               q_add(q_mul(r, tr_vel), q_mul(r, tr_vel)));
    n1 = q_add(tr_pos, q_mul(tr_vel, h));
    tr_vel = q_add(tr_vel, q_mul(fh, h));
    tr_pos = n1;
    // extended observer; halving is a plain truncating divide
    hh  = q_mul(h, h);
    bm1 = beta - ONE;
    sq  = q_mul(bm1, bm1);
    qf  = q_mul(sq, beta + 5 * ONE);
    cf  = q_mul(sq, bm1);
    d   = q_sub(y, ob_pos);
    n1 = q_add(q_mul(h, ob_vel), q_mul(hh, ob_dist) / 64'sd2);
    n1 = q_add(n1, q_mul(3 * beta - 2 * ONE, ob_pos));
    n1 = q_sub(n1, q_mul(3 * beta - 3 * ONE, y));
    n1 = q_add(n1, q_mul(q_mul(b0, hh), ud) / 64'sd2);
    n2 = q_add(ob_vel, q_mul(h, ob_dist));
    n2 = q_add(n2, q_mul(q_mul(b0, h), ud));
    n2 = q_add(n2, q_div(q_mul(d, qf), q_add(h, h)));
    n3 = q_sub(ob_dist, q_div(q_mul(d, cf), hh));
    ob_pos = n1; ob_vel = n2; ob_dist = n3;
    // control law on the updated observer
    e1 = q_sub(tr_pos, y);
    if (op == CMD_ANGLE) begin
      u0 = q_sub(q_mul(kp, e1), q_mul(kd, rate));
      u  = q_sub(u0, q_div(ob_dist, b0));
      if (magn(e1) < gains[REG_INT_WINDOW]) int_sum = q_add(int_sum, q_mul(ki, e1));
      else int_sum = 0;
      u = q_add(u, int_sum);
    end else begin
      u0 = q_sub(q_mul(kp, e1), q_mul(kd, ob_vel));
      u  = q_div(q_sub(u0, ob_dist), b0);
    end
    prev_raw = u0;
    prev_drive = u;
    rec = '{u, u0, tr_pos, ob_dist, sat_seen};
    return rec;
  endfunction

  task automatic compare_q(string name, q_t exp_v, q_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = expected_drives.size();

  always @(posedge clk) begin
    drive_rec_t want;
    if (rst) begin
      gains[REG_STEP_PERIOD] = RST_STEP_PERIOD;
      gains[REG_TRACK_SPEED] = RST_TRACK_SPEED;
      gains[REG_PROP_GAIN]   = RST_PROP_GAIN;
      gains[REG_RATE_GAIN]   = RST_RATE_GAIN;
      gains[REG_PLANT_GAIN]  = RST_PLANT_GAIN;
      gains[REG_POLE_FACTOR] = RST_POLE_FACTOR;
      gains[REG_INT_GAIN]    = RST_INT_GAIN;
      gains[REG_INT_WINDOW]  = RST_INT_WINDOW;
      tr_pos = 0; tr_vel = 0; ob_pos = 0; ob_vel = 0; ob_dist = 0;
      int_sum = 0; prev_drive = 0; prev_raw = 0;
      expected_drives.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_STEP_PERIOD || cfg_index == REG_POLE_FACTOR)
          gains[cfg_index] = {39'd0, cfg_data[24:0]};
        else
          gains[cfg_index] = {23'd0, cfg_data};
      end
      if (sample.valid && sample.ready)
        expected_drives.push_back(adrc_step(sample.op, sample.setpoint,
            sample.applied_drive, sample.measured, sample.measured_rate));
      if (result.valid && result.ready) begin
        results_seen++;
        if (expected_drives.size() == 0) begin
          $error("result transaction with no sample outstanding");
          fail_count++;
        end else begin
          want = expected_drives.pop_front();
          compare_q("drive", want.drive, result.drive);
          compare_q("drive_raw", want.raw, result.drive_raw);
          compare_q("tracked_value", want.tracked, result.tracked_value);
          compare_q("disturbance_estimate", want.est, result.disturbance_estimate);
          if (want.sat !== result.saturated) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.sat, result.saturated);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the ADRC step testbench: clock, reset, sample stimulus, result back-pressure,
// configuration phases and the verdict. Depends on ladrc_pkg, ladrc_if,
// ladrc_step_checker and the block linear_adrc_step_top.
`timescale 1ns / 1ps

module tb_top;
  import ladrc_pkg::*;

  typedef logic signed [63:0] q_t;

  localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t QMIN = 64'sh8000_0000_0000_0000;
  localparam int DRAIN_CYCLES = 800;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int fail_count, pending, results_seen;
  int samples_sent;
  int src_idle_pct, snk_stall_pct;
  bit hold_off_req;

  ladrc_sample_if sample_ch();
  ladrc_result_if result_ch();

  linear_adrc_step_top uut (
    .clk(clk), .rst(rst),
    .sample(sample_ch.sink), .result(result_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ladrc_step_checker chk (
    .clk(clk), .rst(rst),
    .sample(sample_ch), .result(result_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result back-pressure: random stalls, plus one long hold-off on request so the
  // block keeps its result and has to refuse the next sample.
  initial begin
    result_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_ch.ready <= 0;
        repeat (3000) @(negedge clk);
        hold_off_req = 0;
      end
      result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Offer one sample transaction and hold it until it is taken. An idle gap, when
  // chosen, drops valid first; otherwise valid stays high into the next sample.
  task automatic send_sample(logic [1:0] op, q_t sp, q_t ud, q_t y, q_t rate);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk) sample_ch.valid <= 0;
    end
    @(negedge clk);
    sample_ch.valid         <= 1;
    sample_ch.op            <= op;
    sample_ch.setpoint      <= sp;
    sample_ch.applied_drive <= ud;
    sample_ch.measured      <= y;
    sample_ch.measured_rate <= rate;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain();
    @(negedge clk) sample_ch.valid <= 0;
    do @(posedge clk); while (pending != 0 || result_ch.valid);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_gain(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk) cfg_we <= 0;
  endtask

  task automatic write_all(logic [CFG_W-1:0] h, logic [CFG_W-1:0] r, logic [CFG_W-1:0] kp,
                           logic [CFG_W-1:0] kd, logic [CFG_W-1:0] b0,
                           logic [CFG_W-1:0] beta, logic [CFG_W-1:0] ki,
                           logic [CFG_W-1:0] win);
    write_gain(REG_STEP_PERIOD, h);
    write_gain(REG_TRACK_SPEED, r);
    write_gain(REG_PROP_GAIN, kp);
    write_gain(REG_RATE_GAIN, kd);
    write_gain(REG_PLANT_GAIN, b0);
    write_gain(REG_POLE_FACTOR, beta);
    write_gain(REG_INT_GAIN, ki);
    write_gain(REG_INT_WINDOW, win);
  endtask

  function automatic q_t any_q();
    return {$urandom, $urandom};
  endfunction

  // A plant-sized value: within about +-64.0 in Q40.24.
  function automatic q_t plant_q();
    return q_t'($signed($urandom)) >>> 1;
  endfunction

  function automatic logic [CFG_W-1:0] any_gain();
    return CFG_W'({$urandom, $urandom} % (64'd1 << 40));
  endfunction

  // Mostly control samples with plant-sized values; a tenth are full-range noise.
  task automatic random_samples(int count);
    int pick;
    logic [1:0] op;
    repeat (count) begin
      pick = $urandom_range(19);
      op = pick < 9 ? CMD_ANGLE : pick < 17 ? CMD_SPEED : pick == 17 ? CMD_CLEAR : CMD_HOLD;
      if ($urandom_range(9) == 0)
        send_sample(op, any_q(), any_q(), any_q(), any_q());
      else
        send_sample(op, plant_q(), plant_q() >>> 4, plant_q(), plant_q() >>> 2);
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_STEP_PERIOD;
    cfg_data = '0;
    sample_ch.valid = 0;
    sample_ch.op = CMD_ANGLE;
    sample_ch.setpoint = 0;
    sample_ch.applied_drive = 0;
    sample_ch.measured = 0;
    sample_ch.measured_rate = 0;
    samples_sent = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_off_req = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 0;

    // Directed: reset gains, field extremes, every op, clear and hold.
    send_sample(CMD_ANGLE, 0, 0, 0, 0);
    send_sample(CMD_SPEED, 64'sd1 <<< 24, 0, 0, 0);
    send_sample(CMD_HOLD, 0, 0, 0, 0);
    send_sample(CMD_ANGLE, QMAX, QMAX, QMAX, QMAX);
    send_sample(CMD_ANGLE, QMIN, QMIN, QMIN, QMIN);
    send_sample(CMD_SPEED, QMAX, QMIN, QMAX, QMIN);
    send_sample(CMD_SPEED, QMIN, QMAX, QMIN, QMAX);
    send_sample(CMD_HOLD, QMAX, QMAX, QMAX, QMAX);
    send_sample(CMD_CLEAR, QMIN, QMIN, QMIN, QMIN);
    send_sample(CMD_ANGLE, -1, -1, -1, -1);
    send_sample(CMD_SPEED, 1, 1, 1, 1);
    send_sample(CMD_CLEAR, 0, 0, 0, 0);
    send_sample(CMD_SPEED, 64'sd5 <<< 24, 64'sd1 <<< 23, 64'sd2 <<< 24, 0);
    send_sample(CMD_ANGLE, 64'sd5 <<< 24, 64'sd1 <<< 23, 64'sd2 <<< 24, -(64'sd3 <<< 24));
    drain();

    // Mid-range random gains, sender idling.
    src_idle_pct = 47;
    write_all(CFG_W'($urandom_range(1, 16777216)), any_gain(), any_gain(), any_gain(),
              any_gain() | 41'd1, CFG_W'($urandom_range(0, 16777216)), any_gain(),
              any_gain());
    random_samples(50);
    drain();

    // Every gain at its top, receiver stalling.
    src_idle_pct = 0;
    snk_stall_pct = 47;
    write_all(41'd16777216, 41'd1 << 40, 41'd1 << 40, 41'd1 << 40, 41'd1 << 40,
              41'd16777216, 41'd1 << 40, 41'd1 << 40);
    random_samples(40);
    drain();

    // Every gain at its bottom (zero pole, h of one lsb), both sides idling.
    src_idle_pct = 28;
    snk_stall_pct = 28;
    write_all(41'd1, 41'd0, 41'd0, 41'd0, 41'd1, 41'd0, 41'd0, 41'd0);
    random_samples(40);
    drain();

    // Loop-like tuning with a wide integral window; hold the receiver off once.
    src_idle_pct = 0;
    snk_stall_pct = 0;
    write_all(41'd16777, 41'd30 << 24, 41'd6 << 24, 41'd1 << 23, 41'd1 << 24,
              41'd1 << 23, 41'd1 << 22, 41'd40 << 24);
    hold_off_req = 1;
    random_samples(90);
    drain();

    // Reset defaults again with mixed idling.
    src_idle_pct = 47;
    snk_stall_pct = 47;
    write_all(CFG_W'(RST_STEP_PERIOD), RST_TRACK_SPEED, RST_PROP_GAIN, RST_RATE_GAIN,
              RST_PLANT_GAIN, CFG_W'(RST_POLE_FACTOR), RST_INT_GAIN, RST_INT_WINDOW);
    random_samples(80);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d samples over six gain settings (defaults, random, both extremes,",
             samples_sent);
    $display("loop tuning with integral window); %0d results checked.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ladrc_pkg.sv
rtl/core/ladrc_if.sv
rtl/core/ladrc_ram.sv
rtl/core/ladrc_dp.sv
rtl/core/ladrc_ctrl.sv
rtl/core/linear_adrc_step_top.sv
rtl/core/ladrc_checker.sv
tb/ladrc_step_checker.sv
tb/tb_top.sv
